>>> design/date_text_to_day_number_core_macros.svh
// ----------------------------------------------------------------------------
// date text to day number - assertion macros
// shorthand for clocked checks, reset masks every check
// ----------------------------------------------------------------------------
`ifndef DATE_TEXT_TO_DAY_NUMBER_CORE_MACROS_SVH
`define DATE_TEXT_TO_DAY_NUMBER_CORE_MACROS_SVH

// same-cycle implication
`define DATN_CHECK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DATN_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/datn_pkg.sv
// ----------------------------------------------------------------------------
// datn_pkg
// types, constants and tables shared by the date text to day number core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package datn_pkg;

	localparam int unsigned NUM_W     = 17;
	localparam int unsigned ACC_W     = 20;
	localparam int unsigned POS_W     = 2;
	localparam int unsigned FOUND_W   = 2;
	localparam int unsigned NUM_COUNT = 3;
	localparam int unsigned MONTH_W   = 4;
	localparam int unsigned DAY_W     = 5;
	localparam int unsigned DOY_W     = 9;
	localparam int unsigned YP_W      = 17;
	localparam int unsigned Q4_W      = 15;
	localparam int unsigned RECIP_W   = 20;
	localparam int unsigned PROD_W    = Q4_W + RECIP_W;
	localparam int unsigned RECIP_SH  = 24;
	localparam int unsigned Q100_W    = PROD_W - RECIP_SH;
	localparam int unsigned M365_W    = 26;
	localparam int unsigned DAYNUM_W  = 27;

	localparam logic [NUM_W-1:0]   NUM_LIMIT  = 17'd99999;
	// shift of the year so that it is never negative (one full 400 year cycle)
	localparam logic [YP_W-1:0]    YEAR_BIAS  = 17'd400;
	// ceil(2^24 / 25): exact floor division by 25 for any 15 bit value
	localparam logic [RECIP_W-1:0] RECIP_25   = 20'd671089;
	localparam logic [M365_W-1:0]  DAYS_YEAR  = 26'd365;
	// epoch offset plus one 400 year cycle of days for the year bias
	localparam logic signed [DAYNUM_W-1:0] EPOCH_OFFSET = 27'sd865565;

	typedef enum logic [POS_W-1:0] {
		REG_YEAR_POS  = 2'd0,
		REG_MONTH_POS = 2'd1,
		REG_DAY_POS   = 2'd2
	} cfg_reg_t;

	typedef logic [NUM_COUNT-1:0][NUM_W-1:0] num_set_t;

	typedef struct packed {
		logic               ok;
		logic [NUM_W-1:0]   year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_fields_t;

	// pick one of the parsed numbers; an out of range position reads zero
	function automatic logic [NUM_W-1:0] pick_number(input num_set_t nums,
			input logic [POS_W-1:0] pos);
		logic [NUM_W-1:0] val;
		case (pos)
			2'd0:    val = nums[0];
			2'd1:    val = nums[1];
			2'd2:    val = nums[2];
			default: val = '0;
		endcase
		return val;
	endfunction

	// day of the march based year at which each month starts
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] month);
		logic [DOY_W-1:0] doy;
		case (month)
			4'd3:    doy = 9'd0;
			4'd4:    doy = 9'd31;
			4'd5:    doy = 9'd61;
			4'd6:    doy = 9'd92;
			4'd7:    doy = 9'd122;
			4'd8:    doy = 9'd153;
			4'd9:    doy = 9'd184;
			4'd10:   doy = 9'd214;
			4'd11:   doy = 9'd245;
			4'd12:   doy = 9'd275;
			4'd1:    doy = 9'd306;
			4'd2:    doy = 9'd337;
			default: doy = 9'd0;
		endcase
		return doy;
	endfunction

endpackage

>>> design/datn_parse.sv
// ----------------------------------------------------------------------------
// datn_parse
// character tokeniser, field order registers and range check (first stage)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module datn_parse
	import datn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 char_valid,
	output logic                 char_ready,
	input  logic [7:0]           text_char,
	input  logic                 last_char,
	input  logic                 cfg_write,
	input  logic [POS_W-1:0]     cfg_index,
	input  logic [POS_W-1:0]     cfg_data,
	output logic                 date_valid_s1,
	output date_fields_t         date_s1,
	input  logic                 next_ready
);

	localparam logic [FOUND_W-1:0] MAX_FOUND = FOUND_W'(NUM_COUNT);

	logic [POS_W-1:0]   year_pos_q, month_pos_q, day_pos_q;
	logic [NUM_W-1:0]   acc_q;
	logic               in_num_q;
	logic [FOUND_W-1:0] found_q;
	num_set_t           nums_q;

	logic               is_digit;
	logic [ACC_W-1:0]   acc_ext, acc_sum;
	logic [NUM_W-1:0]   acc_sat, acc_1;
	logic               in_1;
	logic [FOUND_W-1:0] found_1, found_2;
	num_set_t           nums_1, nums_2;
	logic [NUM_W-1:0]   year_v, month_v, day_v;
	logic               pos_ok, range_ok;
	logic               s1_ready, take;

	assign is_digit = (text_char >= 8'h30) && (text_char <= 8'h39);
	assign acc_ext  = ACC_W'(acc_q);
	assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(text_char[3:0]);
	assign acc_sat  = (acc_sum > ACC_W'(NUM_LIMIT)) ? NUM_LIMIT : acc_sum[NUM_W-1:0];

	always_comb begin
		acc_1   = acc_q;
		in_1    = in_num_q;
		found_1 = found_q;
		nums_1  = nums_q;
		if (found_q < MAX_FOUND) begin
			if (is_digit) begin
				acc_1 = acc_sat;
				in_1  = 1'b1;
			end else begin
				if (in_num_q) begin
					nums_1[found_q] = acc_q;
					found_1         = found_q + 2'd1;
				end
				acc_1 = '0;
				in_1  = 1'b0;
			end
		end
		// final close of a run still open on the last character
		found_2 = found_1;
		nums_2  = nums_1;
		if (in_1 && (found_1 < MAX_FOUND)) begin
			nums_2[found_1] = acc_1;
			found_2         = found_1 + 2'd1;
		end
	end

	assign year_v   = pick_number(nums_2, year_pos_q);
	assign month_v  = pick_number(nums_2, month_pos_q);
	assign day_v    = pick_number(nums_2, day_pos_q);
	assign pos_ok   = (year_pos_q < POS_W'(NUM_COUNT)) && (month_pos_q < POS_W'(NUM_COUNT))
		&& (day_pos_q < POS_W'(NUM_COUNT));
	assign range_ok = (month_v >= 17'd1) && (month_v <= 17'd12)
		&& (day_v >= 17'd1) && (day_v <= 17'd31);

	assign s1_ready   = !date_valid_s1 || next_ready;
	assign char_ready = s1_ready;
	assign take       = char_valid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_pos_q  <= POS_W'(REG_YEAR_POS);
			month_pos_q <= POS_W'(REG_MONTH_POS);
			day_pos_q   <= POS_W'(REG_DAY_POS);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_YEAR_POS:  year_pos_q  <= cfg_data;
				REG_MONTH_POS: month_pos_q <= cfg_data;
				REG_DAY_POS:   day_pos_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q         <= '0;
			in_num_q      <= 1'b0;
			found_q       <= '0;
			date_valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				if (last_char) begin
					acc_q    <= '0;
					in_num_q <= 1'b0;
					found_q  <= '0;
				end else begin
					acc_q    <= acc_1;
					in_num_q <= in_1;
					found_q  <= found_1;
				end
			end
			if (s1_ready) begin
				date_valid_s1 <= take && last_char;
			end
		end
	end

	// number slots need no reset, the fill count guards them
	always_ff @(posedge clk) begin
		if (take) begin
			nums_q <= nums_1;
		end
		if (take && last_char) begin
			date_s1.ok    <= (found_2 == MAX_FOUND) && pos_ok && range_ok;
			date_s1.year  <= year_v;
			date_s1.month <= month_v[MONTH_W-1:0];
			date_s1.day   <= day_v[DAY_W-1:0];
		end
	end

endmodule

>>> design/datn_days.sv
// ----------------------------------------------------------------------------
// datn_days
// civil date to day count: product stage and final sum into the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module datn_days
	import datn_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       date_valid_s1,
	input  date_fields_t               date_s1,
	output logic                       s2_ready,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       date_valid,
	output logic signed [DAYNUM_W-1:0] day_number
);

	logic                valid_s2, ok_s2;
	logic [M365_W-1:0]   m365_s2;
	logic [Q4_W-1:0]     q4_s2;
	logic [Q100_W-1:0]   q100_s2;
	logic [DOY_W-1:0]    doyd_s2;

	logic                result_valid_q, date_valid_q;
	logic signed [DAYNUM_W-1:0] day_number_q;

	logic [YP_W-1:0]     yp;
	logic [Q4_W-1:0]     q4;
	logic [PROD_W-1:0]   prod;
	logic [M365_W-1:0]   m365;
	logic [DOY_W-1:0]    doyd;
	logic signed [DAYNUM_W-1:0] total;
	logic                out_ready;

	// jan and feb count to the previous year
	assign yp   = date_s1.year + YEAR_BIAS - YP_W'(date_s1.month <= 4'd2);
	assign q4   = yp[YP_W-1:2];
	assign prod = PROD_W'(q4) * PROD_W'(RECIP_25);
	assign m365 = M365_W'(yp) * DAYS_YEAR;
	assign doyd = month_start(date_s1.month) + DOY_W'(date_s1.day) - 9'd1;

	// leap days: y/4 - y/100 + y/400
	assign total = $signed(DAYNUM_W'(m365_s2)) + $signed(DAYNUM_W'(q4_s2))
		- $signed(DAYNUM_W'(q100_s2)) + $signed(DAYNUM_W'(q100_s2 >> 2))
		+ $signed(DAYNUM_W'(doyd_s2)) - EPOCH_OFFSET;

	assign out_ready = !result_valid_q || result_ready;
	assign s2_ready  = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= date_valid_s1;
			end
			if (out_ready) begin
				result_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && date_valid_s1) begin
			ok_s2   <= date_s1.ok;
			m365_s2 <= m365;
			q4_s2   <= q4;
			q100_s2 <= prod[PROD_W-1:RECIP_SH];
			doyd_s2 <= doyd;
		end
		if (out_ready && valid_s2) begin
			date_valid_q <= ok_s2;
			day_number_q <= ok_s2 ? total : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign date_valid   = date_valid_q;
	assign day_number   = day_number_q;

endmodule

>>> design/date_text_to_day_number_core.sv
// ----------------------------------------------------------------------------
// date_text_to_day_number_core
// parses a date string a character at a time and gives days since 1970-01-01
// ----------------------------------------------------------------------------
// channel   | handshake                  | payload
// char      | char_valid / char_ready    | text_char, last_char
// result    | result_valid / result_ready| date_valid, day_number
// cfg       | cfg_write (no wait)        | cfg_index, cfg_data
//
// one character a cycle while char_ready is high; a request with last_char set
// shows its result after passing the parse stage, product stage and result register
// characters without last_char give no result but still wait while char_ready is low
// char_ready falls only while the result register and both stages hold requests
// asynchronous reset clears parse state and sets the field order to y, m, d
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module date_text_to_day_number_core
	import datn_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       char_valid,
	output logic                       char_ready,
	input  logic [7:0]                 text_char,
	input  logic                       last_char,
	input  logic                       cfg_write,
	input  logic [POS_W-1:0]           cfg_index,
	input  logic [POS_W-1:0]           cfg_data,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic                       date_valid,
	output logic signed [DAYNUM_W-1:0] day_number
);

	logic         date_valid_s1;
	date_fields_t date_s1;
	logic         s2_ready;

	datn_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.char_valid    (char_valid),
		.char_ready    (char_ready),
		.text_char     (text_char),
		.last_char     (last_char),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.date_valid_s1 (date_valid_s1),
		.date_s1       (date_s1),
		.next_ready    (s2_ready)
	);

	datn_days u_days (
		.clk           (clk),
		.arst_n        (arst_n),
		.date_valid_s1 (date_valid_s1),
		.date_s1       (date_s1),
		.s2_ready      (s2_ready),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.date_valid    (date_valid),
		.day_number    (day_number)
	);

endmodule

>>> design/datn_checker.sv
// ----------------------------------------------------------------------------
// datn_checker
// port level checks on the date text to day number core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "date_text_to_day_number_core_macros.svh"

module datn_checker
	import datn_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       char_ready,
	input logic                       result_valid,
	input logic                       result_ready,
	input logic                       date_valid,
	input logic signed [DAYNUM_W-1:0] day_number
);

	// a rejected date carries a zero count
	`DATN_CHECK_NOW(a_invalid_zero, result_valid && !date_valid, day_number == '0, "invalid date with nonzero day number")

	// year zero january first is the earliest reachable day
	`DATN_CHECK_NOW(a_day_floor, result_valid && date_valid, day_number >= -27'sd719528, "day number below range")

	// with the result register empty the pipeline always has room
	`DATN_CHECK_NOW(a_ready_when_empty, !result_valid, char_ready, "char request stalled with empty result register")

	// a stalled result holds
	`DATN_CHECK_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(date_valid) && $stable(day_number), "result changed while stalled")

endmodule

bind date_text_to_day_number_core datn_checker u_datn_checker (.*);
